// File: sv/pwfd_pkg.sv
// Shared types and constants for the pulse width frame decoder.
`default_nettype none
package pwfd_pkg;

   localparam int PULSE_W  = 16;
   localparam int CFG_W    = 16;
   localparam int WORD_W   = 14;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_START_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_MARGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_MARGIN = 3'd4;

   localparam logic [CFG_W-1:0] START_WIDTH_RST  = 16'd600;
   localparam logic [CFG_W-1:0] ZERO_WIDTH_RST   = 16'd800;
   localparam logic [CFG_W-1:0] ONE_WIDTH_RST    = 16'd1000;
   localparam logic [CFG_W-1:0] MARGIN_RST       = 16'd100;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] start_width;
      logic [CFG_W-1:0] zero_width;
      logic [CFG_W-1:0] one_width;
      logic [CFG_W-1:0] upper_margin;
      logic [CFG_W-1:0] lower_margin;
   } cfg_type;

endpackage
`default_nettype wire

// File: sv/pwfd_window.sv
// Tolerance window check of one pulse width against a nominal width.
`default_nettype none
module pwfd_window (
   input  wire logic [pwfd_pkg::PULSE_W-1:0] pulse_width,
   input  wire logic [pwfd_pkg::CFG_W-1:0]   nominal,
   input  wire logic [pwfd_pkg::CFG_W-1:0]   upper_margin,
   input  wire logic [pwfd_pkg::CFG_W-1:0]   lower_margin,
   output logic                              hit
);
   import pwfd_pkg::*;

   logic [CFG_W-1:0] low_bound;
   logic [CFG_W:0]   high_bound;
   logic             empty;

   always_comb begin
      empty      = lower_margin > nominal;
      low_bound  = nominal - lower_margin;
      // upper bound kept one bit wider so it cannot wrap
      high_bound = {1'b0, nominal} + {1'b0, upper_margin};
      hit        = !empty && (pulse_width >= low_bound) &&
                   ({1'b0, pulse_width} <= high_bound);
   end

endmodule
`default_nettype wire

// File: sv/pwfd_csr.sv
// Configuration registers of the pulse width frame decoder.
`default_nettype none
module pwfd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pwfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pwfd_pkg::CFG_W-1:0]       csr_data,
   output pwfd_pkg::cfg_type                     cfg
);
   import pwfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START_WIDTH:  cfg_in.start_width  = csr_data;
            REG_ZERO_WIDTH:   cfg_in.zero_width   = csr_data;
            REG_ONE_WIDTH:    cfg_in.one_width    = csr_data;
            REG_UPPER_MARGIN: cfg_in.upper_margin = csr_data;
            REG_LOWER_MARGIN: cfg_in.lower_margin = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_width  <= START_WIDTH_RST;
         cfg_ff.zero_width   <= ZERO_WIDTH_RST;
         cfg_ff.one_width    <= ONE_WIDTH_RST;
         cfg_ff.upper_margin <= MARGIN_RST;
         cfg_ff.lower_margin <= MARGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/pwfd_core.sv
// Input register, pulse classification, frame state and result register.
`default_nettype none
module pwfd_core #(
   parameter int DATA_BITS = 14
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pwfd_pkg::cfg_type              cfg,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [pwfd_pkg::PULSE_W-1:0]   req_pulse_width,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [pwfd_pkg::WORD_W-1:0]         rsp_word,
   output logic                                rsp_status
);
   import pwfd_pkg::*;

   localparam int BL_W = $clog2(DATA_BITS + 1);

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic [PULSE_W-1:0] in_width_ff;
   // frame state
   logic               receiving_ff, receiving_in;
   logic [BL_W-1:0]    bits_left_ff, bits_left_in;
   logic [WORD_W-1:0]  shift_word_ff, shift_word_in;
   // result stage
   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic               out_status_ff, out_status_in;

   logic               out_free;
   logic               advance;
   logic               load_in;
   logic               emit;
   logic               start_hit, zero_hit, one_hit;
   logic [WORD_W-1:0]  next_word;
   logic [BL_W-1:0]    bits_dec;

   pwfd_window u_start_win (
      .pulse_width  (in_width_ff),
      .nominal      (cfg.start_width),
      .upper_margin (cfg.upper_margin),
      .lower_margin (cfg.lower_margin),
      .hit          (start_hit)
   );

   pwfd_window u_zero_win (
      .pulse_width  (in_width_ff),
      .nominal      (cfg.zero_width),
      .upper_margin (cfg.upper_margin),
      .lower_margin (cfg.lower_margin),
      .hit          (zero_hit)
   );

   pwfd_window u_one_win (
      .pulse_width  (in_width_ff),
      .nominal      (cfg.one_width),
      .upper_margin (cfg.upper_margin),
      .lower_margin (cfg.lower_margin),
      .hit          (one_hit)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load_in   = req_valid && !req_stall;

   assign rsp_valid  = out_valid_ff;
   assign rsp_word   = out_word_ff;
   assign rsp_status = out_status_ff;

   // zero window wins when the two data windows overlap
   assign next_word = {shift_word_ff[WORD_W-2:0], !zero_hit};
   assign bits_dec  = (bits_left_ff != '0) ? bits_left_ff - 1'b1 : '0;

   always_comb begin
      in_valid_in   = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      receiving_in  = receiving_ff;
      bits_left_in  = bits_left_ff;
      shift_word_in = shift_word_ff;
      emit          = 1'b0;
      out_word_in   = next_word;
      out_status_in = STATUS_OK;
      if (advance) begin
         if (!receiving_ff) begin
            if (start_hit) begin
               receiving_in  = 1'b1;
               bits_left_in  = BL_W'(DATA_BITS);
               shift_word_in = '0;
            end
         end else if (zero_hit || one_hit) begin
            if (bits_dec == '0) begin
               emit          = 1'b1;
               receiving_in  = 1'b0;
               bits_left_in  = BL_W'(DATA_BITS);
               shift_word_in = '0;
            end else begin
               bits_left_in  = bits_dec;
               shift_word_in = next_word;
            end
         end else begin
            emit          = 1'b1;
            out_word_in   = '0;
            out_status_in = STATUS_ERR;
            receiving_in  = 1'b0;
            bits_left_in  = BL_W'(DATA_BITS);
            shift_word_in = '0;
         end
      end
      out_valid_in = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         receiving_ff  <= 1'b0;
         bits_left_ff  <= BL_W'(DATA_BITS);
         shift_word_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         receiving_ff  <= receiving_in;
         bits_left_ff  <= bits_left_in;
         shift_word_ff <= shift_word_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_width_ff <= req_pulse_width;
      end
      if (emit) begin
         out_word_ff   <= out_word_in;
         out_status_ff <= out_status_in;
      end
   end

   a_err_word_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff == STATUS_ERR) |-> out_word_ff == '0)
      else $error("error result with nonzero word");

   a_emit_ends_frame: assert property (@(posedge clock) disable iff (reset)
      emit |=> !receiving_ff && (bits_left_ff == BL_W'(DATA_BITS)))
      else $error("frame state not cleared after result");

   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> (bits_left_ff != '0) && (bits_left_ff <= BL_W'(DATA_BITS)))
      else $error("bit counter out of range while receiving");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room downstream");

   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      advance && !receiving_ff |-> !emit)
      else $error("result produced while waiting for start");

endmodule
`default_nettype wire

// File: sv/pulse_width_frame_decoder_top.sv
// Top level of the pulse width frame decoder.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_pulse_width   | pulse widths in
//   rsp     | rsp_valid, rsp_stall, rsp_word/status   | frame words out
//   csr     | csr_valid, csr_ready, csr_index/data    | register writes in
//
// One pulse per cycle: a pulse waits in the input register, is classified
// against three windows and updates the frame state, and any result shows
// in the result register the cycle after. Reset restores the register
// defaults and the wait-for-start state. A stalled result holds the pulse
// behind it in the input register; a further pulse is then stalled.
`default_nettype none
module pulse_width_frame_decoder_top #(
   parameter int DATA_BITS = 14
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [pwfd_pkg::PULSE_W-1:0]     req_pulse_width,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [pwfd_pkg::WORD_W-1:0]           rsp_word,
   output logic                                  rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pwfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pwfd_pkg::CFG_W-1:0]       csr_data
);
   import pwfd_pkg::*;

   cfg_type cfg;

   pwfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwfd_core #(
      .DATA_BITS (DATA_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pulse_width (req_pulse_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire
